@@ rtl/core/dst_pkg.sv @@
// dst_pkg: types and constants shared by the divide / square-root tweak step
// used by the serial units, the top level and the test bench
`default_nettype none

package dst_pkg;

  // request codes
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // hash variants that enable the step
  localparam logic [2:0] VARIANT_RESET = 3'd2;
  localparam logic [2:0] VARIANT_V2    = 3'd2;
  localparam logic [2:0] VARIANT_V3    = 3'd3;

  // divisor is forced odd with the top bit set
  localparam logic [31:0] DIV_FORCE = 32'h8000_0001;

  // serial step counts: 33 quotient bits, 34 root bits
  localparam int DIV_STEPS  = 33;
  localparam int SQRT_STEPS = 34;
  localparam int CNT_W      = 6;

  // handshake status of one serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

`default_nettype wire

@@ rtl/core/dst_channels.sv @@
// request and response channel interfaces of the tweak step
// depends on nothing; payload widths are fixed by the field list
`default_nettype none

interface dst_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] c1_low;
  logic [63:0] c2_low;
  logic [63:0] c2_high;
  logic [63:0] seed_division;
  logic [63:0] seed_sqrt;

  modport source (output valid, req_type, c1_low, c2_low, c2_high, seed_division, seed_sqrt,
                  input ready);
  modport sink   (input valid, req_type, c1_low, c2_low, c2_high, seed_division, seed_sqrt,
                  output ready);
endinterface

interface dst_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] c1_low_out;
  logic [63:0] division_out;
  logic [63:0] sqrt_out;

  modport source (output valid, c1_low_out, division_out, sqrt_out, input ready);
  modport sink   (input valid, c1_low_out, division_out, sqrt_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dst_divider.sv @@
// dst_divider: radix-2 restoring divider, 64-bit dividend by a 32-bit divisor
// with bit 31 set; one quotient bit per cycle; uses dst_pkg
`default_nettype none

module dst_divider (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [63:0]      dividend,
  input  wire logic [31:0]      divisor,
  output logic      [31:0]      quotient,
  output logic      [31:0]      remainder,
  output dst_pkg::unit_status_t status
);

  localparam int LOW_W = dst_pkg::DIV_STEPS;

  logic                      busy;
  logic [dst_pkg::CNT_W-1:0] cnt;
  logic [31:0]               rem;
  logic [LOW_W-1:0]          dvd;
  logic [31:0]               quo;
  logic [31:0]               dsr;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;
  logic [31:0] rem_next;

  // one subtract-and-compare step
  always_comb begin
    trial    = {rem, dvd[LOW_W-1]};
    diff     = trial - {1'b0, dsr};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? diff[31:0] : trial[31:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= dst_pkg::CNT_W'(dst_pkg::DIV_STEPS);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // datapath; top 31 dividend bits start the partial remainder, below divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend[63:LOW_W]};
      dvd <= dividend[LOW_W-1:0];
      dsr <= divisor;
      quo <= '0;
    end else if (busy && cnt != '0) begin
      rem <= rem_next;
      dvd <= {dvd[LOW_W-2:0], 1'b0};
      quo <= {quo[30:0], fits};
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = busy && (cnt == '0);

endmodule

`default_nettype wire

@@ rtl/core/dst_isqrt.sv @@
// dst_isqrt: digit-by-digit integer square root of 2^66 + 4x, two operand bits
// per cycle; returns the root minus 2^33; uses dst_pkg
`default_nettype none

module dst_isqrt (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [63:0]      x,
  output logic      [32:0]      root,
  output dst_pkg::unit_status_t status
);

  localparam int ROOT_W = dst_pkg::SQRT_STEPS;
  localparam int OPND_W = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;

  logic                      busy;
  logic [dst_pkg::CNT_W-1:0] cnt;
  logic [OPND_W-1:0]         opnd;
  logic [REM_W-1:0]          rem;
  logic [ROOT_W-1:0]         q;

  logic [REM_W+1:0] shifted;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;
  logic [REM_W-1:0] rem_next;

  // one root digit: compare against 4q+1
  always_comb begin
    shifted  = {rem, opnd[OPND_W-1 -: 2]};
    trial    = {1'b0, q, 2'b01};
    diff     = shifted - trial;
    fits     = shifted >= trial;
    rem_next = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= dst_pkg::CNT_W'(dst_pkg::SQRT_STEPS);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // datapath; operand is 2^66 + 4x
  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= {2'b01, x, 2'b00};
      rem  <= '0;
      q    <= '0;
    end else if (busy && cnt != '0) begin
      opnd <= {opnd[OPND_W-3:0], 2'b00};
      rem  <= rem_next;
      q    <= {q[ROOT_W-2:0], fits};
    end
  end

  // leading root bit is always 2^33
  assign root        = q[32:0];
  assign status.busy = busy;
  assign status.done = busy && (cnt == '0);

endmodule

`default_nettype wire

@@ rtl/core/divide_sqrt_tweak_step.sv @@
// divide_sqrt_tweak_step: top level, variant register, sequencer and state
// depends on dst_pkg, dst_channels, dst_divider and dst_isqrt
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+-----------------------------------------------
//   req     | in  | valid / ready  | req_type, c1_low, c2_low, c2_high, seeds
//   rsp     | out | valid / ready  | c1_low_out, division_out, sqrt_out
//   cfg     | in  | cfg_we         | cfg_wdata (variant)
//
// an active step runs from the accept through the divider (S_DIV), an add state
// (S_ADD), the root (S_SQRT) and write-back (S_DONE); seed and inactive items go
// straight from the accept to write-back. one item is in work at a time; the
// response register holds a finished result while the next item is accepted. a
// stalled response only holds the finished next item in write-back. reset is
// synchronous; the state values clear to zero and variant resets to 2.
`default_nettype none

module divide_sqrt_tweak_step (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  dst_req_if.sink         req,
  dst_rsp_if.source       rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADD,
    S_SQRT,
    S_DONE
  } state_t;

  state_t      state;
  logic [2:0]  variant;
  logic [63:0] division_value;
  logic [63:0] sqrt_value;

  logic [63:0] pend_c1;
  logic [63:0] pend_div;
  logic [63:0] pend_sqrt;
  logic [63:0] c2_low_r;

  logic        req_xfer;
  logic        active;
  logic        div_start;
  logic        sqrt_start;
  logic [31:0] divisor;
  logic [63:0] sqrt_x;
  logic        rsp_free;

  logic [31:0]           quotient;
  logic [31:0]           remainder;
  logic [32:0]           root;
  dst_pkg::unit_status_t div_status;
  dst_pkg::unit_status_t sqrt_status;

  // handshake and step setup
  always_comb begin
    req_xfer   = req.valid && req.ready;
    active     = variant inside {dst_pkg::VARIANT_V2, dst_pkg::VARIANT_V3};
    div_start  = req_xfer && (req.req_type == dst_pkg::REQ_STEP) && active;
    sqrt_start = (state == S_ADD);
    divisor    = (req.c2_low[31:0] + {sqrt_value[30:0], 1'b0}) | dst_pkg::DIV_FORCE;
    sqrt_x     = c2_low_r + pend_div;
    rsp_free   = !rsp.valid || rsp.ready;
  end

  assign req.ready = (state == S_IDLE);

  // variant register
  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= dst_pkg::VARIANT_RESET;
    end else if (cfg_we) begin
      variant <= cfg_wdata;
    end
  end

  // sequencer, state values and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      division_value <= '0;
      sqrt_value     <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      // a transfer empties the register unless write-back refills it
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            c2_low_r <= req.c2_low;
            if (req.req_type == dst_pkg::REQ_SEED) begin
              pend_c1   <= req.c1_low;
              pend_div  <= req.seed_division;
              pend_sqrt <= req.seed_sqrt;
              state     <= S_DONE;
            end else if (active) begin
              pend_c1 <= req.c1_low ^ division_value ^ {sqrt_value[31:0], 32'b0};
              state   <= S_DIV;
            end else begin
              pend_c1   <= req.c1_low;
              pend_div  <= division_value;
              pend_sqrt <= sqrt_value;
              state     <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            pend_div <= {remainder, quotient};
            state    <= S_ADD;
          end
        end
        S_ADD: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_status.done) begin
            pend_sqrt <= {31'b0, root};
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp.valid        <= 1'b1;
            rsp.c1_low_out   <= pend_c1;
            rsp.division_out <= pend_div;
            rsp.sqrt_out     <= pend_sqrt;
            division_value   <= pend_div;
            sqrt_value       <= pend_sqrt;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // serial divider
  dst_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.c2_high),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (div_status)
  );

  // serial square root
  dst_isqrt u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sqrt_start),
    .x      (sqrt_x),
    .root   (root),
    .status (sqrt_status)
  );

endmodule

`default_nettype wire

@@ rtl/core/dst_checker.sv @@
// dst_checker: port-level checks of the tweak step, bound to the top level
// depends on dst_channels through the bind connections
`default_nettype none

module dst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [63:0] rsp_division_out
);

  logic       req_xfer;
  logic       rsp_xfer;
  logic [1:0] pending;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pending <= pending + 1'b1;
    end else if (rsp_xfer && !req_xfer) begin
      pending <= pending - 1'b1;
    end
  end

  // a stalled response keeps valid up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response valid dropped while stalled");

  // a stalled response keeps its division_out payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_division_out))
    else $error("response payload changed while stalled");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req_ready)
    else $error("request accepted while an item is in work");

  // no response without an outstanding request
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response with no outstanding request");

  // at most one finished item waits when a new one is taken
  a_depth: assert property (@(posedge clk) disable iff (rst)
    req_xfer |-> pending <= 2'd1)
    else $error("request accepted with two items outstanding");

endmodule

bind divide_sqrt_tweak_step dst_checker u_dst_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_division_out (rsp.division_out)
);

`default_nettype wire

@@ verif/divide_sqrt_tweak_step_test.sv @@
// divide_sqrt_tweak_step_test: self-checking bench for the divide / square-root tweak step
// depends on dst_pkg, dst_channels and the divide_sqrt_tweak_step top level
// clocked driver and monitor, a bit-true predictor of the state values, random stalls
`default_nettype none

module divide_sqrt_tweak_step_test;

  // variant settings that leave the step inactive
  localparam logic [2:0] VARIANT_V0 = 3'd0;
  localparam logic [2:0] VARIANT_V1 = 3'd1;
  localparam logic [2:0] VARIANT_V4 = 3'd4;

  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          TAIL_CYCLES = 100;
  localparam int          LONG_HOLD   = 400;

  typedef struct {
    logic        req_type;
    logic [63:0] c1_low;
    logic [63:0] c2_low;
    logic [63:0] c2_high;
    logic [63:0] seed_division;
    logic [63:0] seed_sqrt;
  } tweak_req_t;

  typedef struct {
    logic [63:0] c1_low_out;
    logic [63:0] division_out;
    logic [63:0] sqrt_out;
  } tweak_rsp_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  dst_req_if req_ch ();
  dst_rsp_if rsp_ch ();

  divide_sqrt_tweak_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // items waiting to be offered and results waiting to come back
  tweak_req_t req_items_q[$];
  tweak_rsp_t tweak_results_q[$];

  // predictor state
  logic [2:0]  variant_setting;
  logic [63:0] division_state;
  logic [63:0] root_state;

  int   error_count;
  int   send_gap;
  int   rsp_stall;
  int   rsp_hold_cycles;
  bit   quiet_run;
  logic req_fire;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = ~clk;
  end

  // floor(sqrt(2^66 + 4x)) - 2^33, one bit at a time
  function automatic logic [32:0] tweak_root(input logic [63:0] x);
    logic [32:0] root;
    logic [32:0] trial;
    logic [71:0] cand;
    logic [71:0] bound;
    root  = '0;
    bound = (72'd1 << 66) + ({8'd0, x} << 2);
    for (int i = 32; i >= 0; i--) begin
      trial = root | (33'd1 << i);
      cand  = {39'd0, trial} + (72'd1 << 33);
      if (cand * cand <= bound) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // result of one accepted item; advances the predicted state
  function automatic tweak_rsp_t apply_tweak_step(input tweak_req_t item);
    tweak_rsp_t  res;
    logic [31:0] divisor;
    logic [63:0] quot;
    logic [63:0] remd;
    res.c1_low_out = item.c1_low;
    if (item.req_type == dst_pkg::REQ_SEED) begin
      division_state = item.seed_division;
      root_state     = item.seed_sqrt;
    end else if (variant_setting == dst_pkg::VARIANT_V2 ||
                 variant_setting == dst_pkg::VARIANT_V3) begin
      res.c1_low_out = item.c1_low ^ division_state ^ (root_state << 32);
      divisor        = (item.c2_low[31:0] + {root_state[30:0], 1'b0}) | dst_pkg::DIV_FORCE;
      quot           = item.c2_high / {32'd0, divisor};
      remd           = item.c2_high % {32'd0, divisor};
      // only the low 32 quotient bits survive
      division_state = {remd[31:0], quot[31:0]};
      root_state     = {31'd0, tweak_root(item.c2_low + division_state)};
    end
    res.division_out = division_state;
    res.sqrt_out     = root_state;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // driver: offers queued items, holds each until its transfer
  always @(negedge clk) begin
    tweak_req_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_fire) begin
      // still waiting for the transfer
    end else if (send_gap > 0) begin
      send_gap--;
      req_ch.valid <= 1'b0;
    end else if (req_items_q.size() > 0) begin
      item = req_items_q.pop_front();
      req_ch.req_type      <= item.req_type;
      req_ch.c1_low        <= item.c1_low;
      req_ch.c2_low        <= item.c2_low;
      req_ch.c2_high       <= item.c2_high;
      req_ch.seed_division <= item.seed_division;
      req_ch.seed_sqrt     <= item.seed_sqrt;
      req_ch.valid         <= 1'b1;
      if (!quiet_run && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 12);
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // receiver: long hold-off on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_hold_cycles > 0) begin
      rsp_hold_cycles--;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
      rsp_stall = $urandom_range(0, 11);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor: predicts on each request transfer, checks each response transfer
  always @(posedge clk) begin
    tweak_req_t item;
    tweak_rsp_t want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        item.req_type      = req_ch.req_type;
        item.c1_low        = req_ch.c1_low;
        item.c2_low        = req_ch.c2_low;
        item.c2_high       = req_ch.c2_high;
        item.seed_division = req_ch.seed_division;
        item.seed_sqrt     = req_ch.seed_sqrt;
        tweak_results_q.push_back(apply_tweak_step(item));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (tweak_results_q.size() == 0) begin
          report_mismatch("unexpected result c1_low_out", rsp_ch.c1_low_out, '0);
        end else begin
          want = tweak_results_q.pop_front();
          if (rsp_ch.c1_low_out !== want.c1_low_out)
            report_mismatch("c1_low_out", rsp_ch.c1_low_out, want.c1_low_out);
          if (rsp_ch.division_out !== want.division_out)
            report_mismatch("division_out", rsp_ch.division_out, want.division_out);
          if (rsp_ch.sqrt_out !== want.sqrt_out)
            report_mismatch("sqrt_out", rsp_ch.sqrt_out, want.sqrt_out);
        end
      end
    end
  end

  // random word biased toward the edges
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return 64'($urandom_range(0, 255));
      3: return 64'd1 << $urandom_range(0, 63);
      4: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_step(input logic [63:0] c1, input logic [63:0] c2lo,
                            input logic [63:0] c2hi);
    tweak_req_t item;
    item.req_type      = dst_pkg::REQ_STEP;
    item.c1_low        = c1;
    item.c2_low        = c2lo;
    item.c2_high       = c2hi;
    item.seed_division = rand_word();
    item.seed_sqrt     = rand_word();
    req_items_q.push_back(item);
  endtask

  task automatic queue_seed(input logic [63:0] div_seed, input logic [63:0] root_seed);
    tweak_req_t item;
    item.req_type      = dst_pkg::REQ_SEED;
    item.c1_low        = rand_word();
    item.c2_low        = rand_word();
    item.c2_high       = rand_word();
    item.seed_division = div_seed;
    item.seed_sqrt     = root_seed;
    req_items_q.push_back(item);
  endtask

  // mostly steps, now and then a reseed of either kind
  task automatic queue_random_items(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_seed(rand_word(), {31'd0, 1'b0, $urandom});
        end else begin
          queue_seed(rand_word(), rand_word());
        end
      end else begin
        queue_step(rand_word(), rand_word(), rand_word());
      end
    end
  endtask

  // sender pause until every queued item has come back
  task automatic wait_all_returned();
    while (req_items_q.size() > 0 || req_ch.valid || tweak_results_q.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_variant(input logic [2:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    variant_setting = value;
  endtask

  // stimulus
  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = dst_pkg::REQ_SEED;
    req_ch.c1_low        = '0;
    req_ch.c2_low        = '0;
    req_ch.c2_high       = '0;
    req_ch.seed_division = '0;
    req_ch.seed_sqrt     = '0;
    rsp_ch.ready         = 1'b0;
    req_fire             = 1'b0;
    error_count          = 0;
    send_gap             = 0;
    rsp_stall            = 0;
    rsp_hold_cycles      = 0;
    quiet_run            = 1'b0;
    variant_setting      = dst_pkg::VARIANT_RESET;
    division_state       = '0;
    root_state           = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset state, field extremes, wide quotient, oversized seeds
    queue_step('0, '0, '0);
    queue_step(ALL_ONES, ALL_ONES, ALL_ONES);
    queue_seed(ALL_ONES, ALL_ONES);
    queue_step('0, '0, ALL_ONES);
    queue_seed('0, '0);
    queue_step(64'h0123_4567_89AB_CDEF, '0, ALL_ONES);
    queue_step(ALL_ONES, 64'hFFFF_FFFF_7FFF_FFFE, '0);
    queue_seed(64'h8000_0000_0000_0000, 64'h0000_0001_FFFF_FFFF);
    queue_step(rand_word(), rand_word(), 64'h8000_0000_0000_0000);
    queue_step({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    wait_all_returned();

    write_variant(dst_pkg::VARIANT_V3);
    queue_step(ALL_ONES, ALL_ONES, ALL_ONES);
    queue_step({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    wait_all_returned();

    // inactive variants pass data through and keep the state
    write_variant(VARIANT_V0);
    queue_step(ALL_ONES, ALL_ONES, ALL_ONES);
    queue_seed(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_step('0, '0, ALL_ONES);
    wait_all_returned();
    write_variant(VARIANT_V4);
    queue_step(rand_word(), rand_word(), rand_word());
    wait_all_returned();
    write_variant(VARIANT_V1);
    queue_step(rand_word(), rand_word(), rand_word());
    wait_all_returned();

    // random, with a long response hold-off while items keep coming
    write_variant(dst_pkg::VARIANT_V2);
    queue_random_items(450);
    @(posedge clk);
    rsp_hold_cycles = LONG_HOLD;
    wait_all_returned();

    write_variant(dst_pkg::VARIANT_V3);
    queue_random_items(400);
    wait_all_returned();

    write_variant(VARIANT_V0);
    queue_random_items(40);
    wait_all_returned();
    write_variant(VARIANT_V4);
    queue_random_items(40);
    wait_all_returned();
    write_variant(VARIANT_V1);
    queue_random_items(40);
    wait_all_returned();

    // last stretch back to back on both sides
    write_variant(dst_pkg::VARIANT_V2);
    quiet_run = 1'b1;
    queue_random_items(260);
    wait_all_returned();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tweak_results_q.size() > 0) begin
      report_mismatch("results never returned", 64'(tweak_results_q.size()), '0);
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/dst_pkg.sv
rtl/core/dst_channels.sv
rtl/core/dst_divider.sv
rtl/core/dst_isqrt.sv
rtl/core/divide_sqrt_tweak_step.sv
rtl/core/dst_checker.sv
verif/divide_sqrt_tweak_step_test.sv
